// ===== rtl/vvfm_pkg.sv =====
// Shared types and constants of the visible-face mesher.
package vvfm_pkg;

  localparam int unsigned WIDTH_CELLS_DEF  = 16;
  localparam int unsigned HEIGHT_CELLS_DEF = 256;
  localparam int unsigned DEPTH_CELLS_DEF  = 16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FACE_COUNT  = 6;
  localparam int unsigned KIND_W      = 2;

  localparam logic        CMD_WRITE = 1'b0;
  localparam logic        CMD_MESH  = 1'b1;
  localparam logic [1:0]  KIND_AIR  = 2'd0;

  localparam logic [2:0]  FACE_PX = 3'd0;
  localparam logic [2:0]  FACE_NX = 3'd1;
  localparam logic [2:0]  FACE_PY = 3'd2;
  localparam logic [2:0]  FACE_NY = 3'd3;
  localparam logic [2:0]  FACE_PZ = 3'd4;
  localparam logic [2:0]  FACE_NZ = 3'd5;

  typedef struct packed {
    logic       command;
    logic [3:0] in_x;
    logic [7:0] in_y;
    logic [3:0] in_z;
    logic [1:0] in_kind;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] out_x;
    logic [7:0] out_y;
    logic [3:0] out_z;
    logic [2:0] face_dir;
    logic [1:0] out_kind;
    logic       face_valid;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    in_beat_t                beat;
    logic                    in_chunk;
    logic [FACE_COUNT-1:0]   edge_hit;
  } cmd_entry_t;

endpackage

// ===== rtl/voxel_visible_face_mesher.sv =====
// Top level of the visible-face mesher for one voxel chunk.
//
// A beat is taken when start is high and busy is low; a two-entry command queue sits in
// front of the executing logic. A write command inside the chunk writes the store as
// it leaves the queue. A mesh command reads the cell and its six neighbours one per cycle
// through the single port of the block store; a solid cell then gives one result per
// exposed face (0 to 6), an air cell or a cell outside the chunk a single result.
// Each result beat is shown for one cycle with out_strobe high and must be taken then;
// the receiver cannot stall. A solid cell with no exposed face gives no result.
module voxel_visible_face_mesher #(
  parameter int unsigned WIDTH_CELLS  = vvfm_pkg::WIDTH_CELLS_DEF,
  parameter int unsigned HEIGHT_CELLS = vvfm_pkg::HEIGHT_CELLS_DEF,
  parameter int unsigned DEPTH_CELLS  = vvfm_pkg::DEPTH_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vvfm_pkg::in_beat_t   in_beat,
  output logic                 out_strobe,
  output vvfm_pkg::out_beat_t  out_beat
);
  import vvfm_pkg::*;

  localparam int unsigned AW = $clog2(WIDTH_CELLS) + $clog2(HEIGHT_CELLS)
                             + $clog2(DEPTH_CELLS);

  logic              head_vld;
  cmd_entry_t        head;
  logic              pop;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [KIND_W-1:0] ram_wdata;
  logic [KIND_W-1:0] ram_rdata;

  vvfm_front #(
    .WIDTH_CELLS (WIDTH_CELLS),
    .HEIGHT_CELLS(HEIGHT_CELLS),
    .DEPTH_CELLS (DEPTH_CELLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_beat (in_beat),
    .head_vld(head_vld),
    .head    (head),
    .pop     (pop)
  );

  vvfm_back #(
    .WIDTH_CELLS (WIDTH_CELLS),
    .HEIGHT_CELLS(HEIGHT_CELLS),
    .DEPTH_CELLS (DEPTH_CELLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (head_vld),
    .head      (head),
    .pop       (pop),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_strobe(out_strobe),
    .out_beat  (out_beat)
  );

  vvfm_ram #(
    .WIDTH(KIND_W),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule

// ===== rtl/vvfm_ram.sv =====
// Generic single-port RAM with registered read data.
module vvfm_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/vvfm_front.sv =====
// Command intake: classifies each beat against the chunk bounds and queues it.
module vvfm_front #(
  parameter int unsigned WIDTH_CELLS  = vvfm_pkg::WIDTH_CELLS_DEF,
  parameter int unsigned HEIGHT_CELLS = vvfm_pkg::HEIGHT_CELLS_DEF,
  parameter int unsigned DEPTH_CELLS  = vvfm_pkg::DEPTH_CELLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  vvfm_pkg::in_beat_t     in_beat,
  output logic                   head_vld,
  output vvfm_pkg::cmd_entry_t   head,
  input  logic                   pop
);
  import vvfm_pkg::*;

  localparam int unsigned QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);

  cmd_entry_t     mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           accept;
  cmd_entry_t     entry;
  logic [31:0]    xw, yw, zw;

  always_comb begin
    xw = 32'(in_beat.in_x);
    yw = 32'(in_beat.in_y);
    zw = 32'(in_beat.in_z);
    entry.beat     = in_beat;
    entry.in_chunk = (xw < WIDTH_CELLS) && (yw < HEIGHT_CELLS) && (zw < DEPTH_CELLS);
    entry.edge_hit = {zw == 32'd0, zw == DEPTH_CELLS - 1,
                      yw == 32'd0, yw == HEIGHT_CELLS - 1,
                      xw == 32'd0, xw == WIDTH_CELLS - 1};
  end

  assign busy     = (count_r == CW'(QUEUE_DEPTH));
  assign accept   = start && !busy;
  assign head_vld = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (accept && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !accept) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow an accepted beat");

endmodule

// ===== rtl/vvfm_back.sv =====
// Command execution: store writes, seven-cell neighbour reads and face emission.
module vvfm_back #(
  parameter int unsigned WIDTH_CELLS  = vvfm_pkg::WIDTH_CELLS_DEF,
  parameter int unsigned HEIGHT_CELLS = vvfm_pkg::HEIGHT_CELLS_DEF,
  parameter int unsigned DEPTH_CELLS  = vvfm_pkg::DEPTH_CELLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_vld,
  input  vvfm_pkg::cmd_entry_t   head,
  output logic                   pop,
  output logic                   ram_we,
  output logic [$clog2(WIDTH_CELLS)+$clog2(HEIGHT_CELLS)+$clog2(DEPTH_CELLS)-1:0] ram_addr,
  output logic [vvfm_pkg::KIND_W-1:0] ram_wdata,
  input  logic [vvfm_pkg::KIND_W-1:0] ram_rdata,
  output logic                   out_strobe,
  output vvfm_pkg::out_beat_t    out_beat
);
  import vvfm_pkg::*;

  localparam int unsigned XW = $clog2(WIDTH_CELLS);
  localparam int unsigned YW = $clog2(HEIGHT_CELLS);
  localparam int unsigned ZW = $clog2(DEPTH_CELLS);
  localparam int unsigned AW = XW + YW + ZW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_FACES = 2'd2;
  localparam logic [1:0] ST_AIR   = 2'd3;

  localparam logic [2:0] IDX_CENTER = 3'd0;
  localparam logic [2:0] IDX_LAST   = 3'd6;
  localparam logic [2:0] IDX_DONE   = 3'd7;

  logic [1:0]            state_r, state_nxt;
  cmd_entry_t            cur_r, cur_nxt;
  logic [2:0]            rd_idx_r, rd_idx_nxt;
  logic                  ret_vld_r, ret_vld_nxt;
  logic [2:0]            ret_idx_r, ret_idx_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [FACE_COUNT-1:0] mask_r, mask_nxt;
  logic                  issue;
  logic [31:0]           cx, cy, cz, nx, ny, nz;
  logic [2:0]            face_bit;
  logic [2:0]            sel_dir;
  logic [FACE_COUNT-1:0] rest;

  function automatic logic [AW-1:0] cell_addr(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {x[XW-1:0], y[YW-1:0], z[ZW-1:0]};
  endfunction

  assign issue = (state_r == ST_READ) && (rd_idx_r != IDX_DONE);
  assign pop   = (state_r == ST_IDLE) && head_vld;

  always_comb begin
    cx = 32'(cur_r.beat.in_x);
    cy = 32'(cur_r.beat.in_y);
    cz = 32'(cur_r.beat.in_z);
    nx = cx;
    ny = cy;
    nz = cz;
    unique case (rd_idx_r)
      3'd1:    nx = cx + 32'd1;
      3'd2:    nx = cx - 32'd1;
      3'd3:    ny = cy + 32'd1;
      3'd4:    ny = cy - 32'd1;
      3'd5:    nz = cz + 32'd1;
      3'd6:    nz = cz - 32'd1;
      default: ;
    endcase
  end

  always_comb begin
    ram_wdata = head.beat.in_kind;
    ram_we    = pop && (head.beat.command == CMD_WRITE) && head.in_chunk;
    if (state_r == ST_IDLE) begin
      ram_addr = cell_addr(32'(head.beat.in_x), 32'(head.beat.in_y), 32'(head.beat.in_z));
    end else begin
      ram_addr = cell_addr(nx, ny, nz);
    end
  end

  always_comb begin
    sel_dir = FACE_PX;
    for (int i = FACE_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel_dir = 3'(i);
      end
    end
    rest = mask_r & ~(FACE_COUNT'(1) << sel_dir);
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    rd_idx_nxt  = rd_idx_r;
    kind_nxt    = kind_r;
    mask_nxt    = mask_r;
    ret_vld_nxt = issue;
    ret_idx_nxt = rd_idx_r;
    face_bit    = 3'(ret_idx_r - 3'd1);
    out_strobe  = 1'b0;
    out_beat.out_x      = cur_r.beat.in_x;
    out_beat.out_y      = cur_r.beat.in_y;
    out_beat.out_z      = cur_r.beat.in_z;
    out_beat.face_dir   = FACE_PX;
    out_beat.out_kind   = KIND_AIR;
    out_beat.face_valid = 1'b0;
    out_beat.last       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          cur_nxt    = head;
          rd_idx_nxt = IDX_CENTER;
          mask_nxt   = '0;
          if (head.beat.command == CMD_MESH) begin
            state_nxt = head.in_chunk ? ST_READ : ST_AIR;
          end
        end
      end
      ST_READ: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 3'd1;
        end
        if (ret_vld_r) begin
          if (ret_idx_r == IDX_CENTER) begin
            kind_nxt = ram_rdata;
            if (ram_rdata == KIND_AIR) begin
              state_nxt = ST_AIR;
            end
          end else begin
            mask_nxt[face_bit] = cur_r.edge_hit[face_bit] || (ram_rdata == KIND_AIR);
            if (ret_idx_r == IDX_LAST) begin
              state_nxt = (mask_nxt != '0) ? ST_FACES : ST_IDLE;
            end
          end
        end
      end
      ST_FACES: begin
        out_strobe          = 1'b1;
        out_beat.face_dir   = sel_dir;
        out_beat.out_kind   = kind_r;
        out_beat.face_valid = 1'b1;
        out_beat.last       = (rest == '0);
        mask_nxt            = rest;
        if (rest == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_AIR: begin
        out_strobe = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ret_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_vld_r <= ret_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    rd_idx_r  <= rd_idx_nxt;
    ret_idx_r <= ret_idx_nxt;
    kind_r    <= kind_nxt;
    mask_r    <= mask_nxt;
  end

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("store written while a mesh command is in flight");

  a_face_solid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_beat.face_valid) |-> (out_beat.out_kind != KIND_AIR))
    else $error("face reported for an air cell");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_beat.last) |=> !out_strobe)
    else $error("result followed the last result of a command");

  a_faces_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FACES) |-> (mask_r != '0))
    else $error("face emission with no exposed face left");

endmodule
